/* hdl/sle_pkg.sv */
// Package for the serial line editor: byte codes, result kinds, state and
// source encodings, and the command/status structs between control and datapath.
// No dependencies.
package sle_pkg;

  // Default line store depth, in characters
  localparam int DefLineCapacity = 32;

  // Received byte codes
  localparam logic [7:0] ChrCr      = 8'd13;
  localparam logic [7:0] ChrLf      = 8'd10;
  localparam logic [7:0] ChrDel     = 8'd127;
  localparam logic [7:0] ChrBracket = 8'd91;
  localparam logic [7:0] ChrPrintLo = 8'd32;
  localparam logic [7:0] ChrPrintHi = 8'd126;

  // Result kinds
  localparam logic [1:0] KindEcho = 2'd0;
  localparam logic [1:0] KindChar = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO,
    ST_CR_ECHO,
    ST_LF_ECHO,
    ST_CHAR,
    ST_END
  } sle_state_t;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SRC_RX,
    SRC_CR,
    SRC_LF,
    SRC_MEM,
    SRC_ZERO
  } sle_src_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     accept;    // latch rx byte
    logic     skip_set;
    logic     skip_clr;
    logic     store;     // store rx byte if there is room
    logic     del;       // step the fill count back
    logic     line_clr;  // empty the line
    logic     rd_start;  // point the read index at the first character
    logic     rd_step;   // advance the read index
    logic     out_load;  // load a result into the output register
    sle_src_t out_src;
    logic     out_last;
  } sle_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic skip;       // skip pending
    logic is_cr;
    logic is_del;
    logic is_bracket;
    logic is_print;
    logic out_free;   // output register can take a beat this cycle
    logic rd_done;    // read index at the end of the line
    logic rd_final;   // read index on the last character of the line
  } sle_status_t;

endpackage

/* hdl/serial_line_editor.sv */
// Top level of the serial line editor: controller plus datapath.
// Depends on sle_pkg, sle_ctrl and sle_dp.
//
//  channel | direction | handshake           | payload
//  rx      | in        | rx_valid / rx_stall | rx_byte
//  out     | out       | out_valid/out_stall | out_kind, out_byte, out_last
//
// A dropped or ignored byte only goes through decode, an echoed byte also the echo
// state, and a carriage return the CR and LF echoes, the stored characters and the
// line end, the controller stepping the line store one read per unstalled cycle.
// One result beat sits in the output register; a new byte is taken while it waits.
// Reset (rst, synchronous) empties the line and clears the skip flag; the
// store itself is not cleared. A stall on the output holds the dump in place.
module serial_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = DefLineCapacity
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  sle_cmd_t    cmd;
  sle_status_t status;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sle_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

/* hdl/sle_ctrl.sv */
// Controller of the serial line editor: sequences decode, echoes and the
// line dump. Depends on sle_pkg.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  sle_status_t status,
  output sle_cmd_t    cmd
);

  sle_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (rx_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (status.skip)            state_next = ST_IDLE;
        else if (status.is_cr)      state_next = ST_CR_ECHO;
        else if (status.is_del)     state_next = ST_ECHO;
        else if (status.is_bracket) state_next = ST_IDLE;
        else if (status.is_print)   state_next = ST_ECHO;
        else                        state_next = ST_IDLE;
      end
      ST_ECHO: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_CR_ECHO: begin
        if (status.out_free) state_next = ST_LF_ECHO;
      end
      ST_LF_ECHO: begin
        if (status.out_free) state_next = status.rd_done ? ST_END : ST_CHAR;
      end
      ST_CHAR: begin
        if (status.out_free && status.rd_final) state_next = ST_END;
      end
      ST_END: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.out_src = SRC_RX;
    rx_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        rx_stall   = 1'b0;
        cmd.accept = rx_valid;
      end
      ST_DECODE: begin
        if (status.skip)            cmd.skip_clr = 1'b1;
        else if (status.is_cr)      cmd.rd_start = 1'b1;
        else if (status.is_del)     cmd.del      = 1'b1;
        else if (status.is_bracket) cmd.skip_set = 1'b1;
        else if (status.is_print)   cmd.store    = 1'b1;
      end
      ST_ECHO: begin
        cmd.out_load = status.out_free;
        cmd.out_src  = SRC_RX;
        cmd.out_last = 1'b1;
      end
      ST_CR_ECHO: begin
        cmd.out_load = status.out_free;
        cmd.out_src  = SRC_CR;
      end
      ST_LF_ECHO: begin
        cmd.out_load = status.out_free;
        cmd.out_src  = SRC_LF;
      end
      ST_CHAR: begin
        cmd.out_load = status.out_free;
        cmd.rd_step  = status.out_free;
        cmd.out_src  = SRC_MEM;
      end
      ST_END: begin
        cmd.out_load = status.out_free;
        cmd.line_clr = status.out_free;
        cmd.out_src  = SRC_ZERO;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* hdl/sle_dp.sv */
// Datapath of the serial line editor: byte register, line store, fill count,
// skip flag, read index and output register. Depends on sle_pkg.
module sle_dp
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = DefLineCapacity
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  sle_cmd_t    cmd,
  output sle_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

  logic [7:0]       rx_reg;
  logic [7:0]       line_mem [LINE_CAPACITY];
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] rd_addr;
  logic             skip, skip_next;
  logic             room;
  logic             out_free;
  logic [7:0]       load_byte;
  logic [1:0]       load_kind;

  // Received byte
  always_ff @(posedge clk) begin
    if (cmd.accept) rx_reg <= rx_byte;
  end

  // Byte classes
  assign room = fill_count < CAP;
  always_comb begin
    status.skip       = skip;
    status.is_cr      = rx_reg == ChrCr;
    status.is_del     = rx_reg == ChrDel;
    status.is_bracket = rx_reg == ChrBracket;
    status.is_print   = (rx_reg >= ChrPrintLo) && (rx_reg <= ChrPrintHi);
    status.out_free   = out_free;
    status.rd_done    = rd_idx == fill_count;
    status.rd_final   = (rd_idx + 1'b1) == fill_count;
  end

  // Fill count and skip flag
  always_comb begin
    fill_count_next = fill_count;
    if (cmd.line_clr) fill_count_next = '0;
    else if (cmd.del && fill_count != '0) fill_count_next = fill_count - 1'b1;
    else if (cmd.store && room) fill_count_next = fill_count + 1'b1;
    skip_next = skip;
    if (cmd.skip_set) skip_next = 1'b1;
    else if (cmd.skip_clr) skip_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      skip       <= 1'b0;
      rd_idx     <= '0;
    end else begin
      fill_count <= fill_count_next;
      skip       <= skip_next;
      rd_idx     <= rd_idx_next;
    end
  end

  // Read index; the store is read at rd_idx_next so the registered rd_data matches rd_idx
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.rd_start) rd_idx_next = '0;
    else if (cmd.rd_step) rd_idx_next = rd_idx + 1'b1;
    rd_addr = (rd_idx_next < CAP) ? rd_idx_next[IDX_W-1:0] : '0;
  end

  // Line store
  always_ff @(posedge clk) begin
    if (cmd.store && room) line_mem[fill_count[IDX_W-1:0]] <= rx_reg;
    rd_data <= line_mem[rd_addr];
  end

  // Result source select
  always_comb begin
    unique case (cmd.out_src)
      SRC_RX:   begin load_byte = rx_reg;  load_kind = KindEcho; end
      SRC_CR:   begin load_byte = ChrCr;   load_kind = KindEcho; end
      SRC_LF:   begin load_byte = ChrLf;   load_kind = KindEcho; end
      SRC_MEM:  begin load_byte = rd_data; load_kind = KindChar; end
      SRC_ZERO: begin load_byte = '0;      load_kind = KindEnd;  end
      default:  begin load_byte = '0;      load_kind = KindEnd;  end
    endcase
  end

  // Output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= load_kind;
      out_byte <= load_byte;
      out_last <= cmd.out_last;
    end
  end

endmodule

/* hdl/sle_checker.sv */
// Port-level checker for the serial line editor, bound to the top level.
// Depends on sle_pkg and serial_line_editor.
module sle_checker
  import sle_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_last))
    else $error("stalled result beat changed");

  // Line end carries a zero byte and closes the results of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KindEnd |-> out_byte == 8'd0 && out_last)
    else $error("malformed line end beat");

  // A line character is never the last result
  a_char_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KindChar |-> !out_last)
    else $error("line character marked last");

  // After taking a byte the block is busy decoding it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    rx_valid && !rx_stall |=> rx_stall)
    else $error("byte taken while decoding");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);
